@@ hw/rtl/fifo_job_server_with_statistics_unit_macros.svh @@
// Assertion macros shared by the job server modules.
// Each macro expects the module to have aclk and aresetn in scope.
`ifndef FIFO_JOB_SERVER_WITH_STATISTICS_UNIT_MACROS_SVH
`define FIFO_JOB_SERVER_WITH_STATISTICS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FJS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FJS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/fjs_pkg.sv @@
package fjs_pkg;

    // Queue and job sizing.
    localparam int QUEUE_DEPTH = 16;
    localparam int PAGE_BITS   = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);

    // Statistics widths.
    localparam int TICK_W    = 32;
    localparam int SUM_W     = 36;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // Stream widths.
    localparam int FUNC_W     = 2;
    localparam int IN_DATA_W  = 16;
    localparam int RES_W      = 2 + PAGE_BITS + LEN_W + 3 * TICK_W + 2 * LEN_W + 1;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W      = OUT_DATA_W - RES_W;

    // Request kinds carried on the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SUBMIT = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_WAIT,
        ST_PULL,
        ST_SUBMIT,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic tick;
        logic pull;
        logic submit;
        logic div_start;
        logic load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_zero;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // Result layout; the last member sits in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0]     pad;
        logic                 average_valid;
        logic [LEN_W-1:0]     average_queue_length;
        logic [LEN_W-1:0]     max_queue_length;
        logic [TICK_W-1:0]    elapsed_ticks;
        logic [TICK_W-1:0]    idle_ticks;
        logic [TICK_W-1:0]    work_ticks;
        logic [LEN_W-1:0]     queue_length;
        logic [PAGE_BITS-1:0] pages_left;
        logic                 busy_res;
        logic                 job_dropped;
    } result_t;

endpackage

@@ hw/rtl/fifo_job_server_with_statistics_unit.sv @@
// Single-server job queue with running statistics. Each request on the s_ side is a
// time tick, a job submit, a statistics read or the unused code, and each produces
// exactly one status result on the m_ side. One request is handled at a time: a
// tick pulls and serves a page, waits for the job memory's registered read, does a
// second pull and loads the result; a submit updates the queue and loads a result;
// a statistics read runs the 36-step restoring divider that forms the average queue
// length (a read before any tick skips the divider). A new request is taken while
// the previous result still waits on the m_ side.
module fifo_job_server_with_statistics_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fjs_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] page_count
    input  logic [fjs_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] job_dropped, [1] busy_res, [17:2] pages_left, [22:18] queue_length,
    // [54:23] work_ticks, [86:55] idle_ticks, [118:87] elapsed_ticks,
    // [123:119] max_queue_length, [128:124] average_queue_length,
    // [129] average_valid, [135:130] zero
    output logic [fjs_pkg::OUT_DATA_W-1:0]  m_tdata
);

    fjs_pkg::dp_cmd_t    cmd;
    fjs_pkg::dp_status_t status;

    fjs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fjs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/fjs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fjs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fjs_pkg::SUM_W-1:0]   dividend,
    input  logic [fjs_pkg::TICK_W-1:0]  divisor,
    output logic                        busy,
    output logic [fjs_pkg::SUM_W-1:0]   quotient
);

    logic [fjs_pkg::TICK_W:0]       rem_reg;
    logic [fjs_pkg::TICK_W:0]       rem_next;
    logic [fjs_pkg::SUM_W-1:0]      quo_reg;
    logic [fjs_pkg::SUM_W-1:0]      quo_next;
    logic [fjs_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [fjs_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic [fjs_pkg::TICK_W:0]       shifted;
    logic                           fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    // Shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg[fjs_pkg::TICK_W-1:0], quo_reg[fjs_pkg::SUM_W-1]};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = fjs_pkg::DIV_CNT_W'(fjs_pkg::SUM_W);
        end else if (busy) begin
            rem_next = fits ? (shifted - {1'b0, divisor}) : shifted;
            quo_next = {quo_reg[fjs_pkg::SUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

@@ hw/rtl/fjs_dp.sv @@
// Job FIFO, server state, statistics counters and the result register.
module fjs_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fjs_pkg::dp_cmd_t                cmd,
    output fjs_pkg::dp_status_t             status,
    input  logic [fjs_pkg::FUNC_W-1:0]      s_tuser,
    input  logic [fjs_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fjs_pkg::OUT_DATA_W-1:0]  m_tdata
);

    `include "fifo_job_server_with_statistics_unit_macros.svh"

    // Job storage and its registered read port.
    logic [fjs_pkg::PAGE_BITS-1:0] mem [fjs_pkg::QUEUE_DEPTH];
    logic [fjs_pkg::PAGE_BITS-1:0] rd_data_reg;

    // Request payload.
    logic [fjs_pkg::FUNC_W-1:0]    func_reg;
    logic [fjs_pkg::PAGE_BITS-1:0] page_reg;
    logic                          dropped_reg;

    // Queue and server state.
    logic [fjs_pkg::IDX_W-1:0]     head_reg,    head_next;
    logic [fjs_pkg::IDX_W-1:0]     tail_reg,    tail_next;
    logic [fjs_pkg::LEN_W-1:0]     count_reg,   count_next;
    logic                          serving_reg, serving_next;
    logic [fjs_pkg::PAGE_BITS-1:0] pages_reg,   pages_next;

    // Statistics.
    logic [fjs_pkg::TICK_W-1:0]    work_reg,  work_next;
    logic [fjs_pkg::TICK_W-1:0]    idle_reg,  idle_next;
    logic [fjs_pkg::TICK_W-1:0]    tick_reg,  tick_next;
    logic [fjs_pkg::SUM_W-1:0]     sum_reg,   sum_next;
    logic [fjs_pkg::LEN_W-1:0]     peak_reg,  peak_next;

    // Result register.
    logic                          out_valid_reg;
    fjs_pkg::result_t              out_data_reg;
    fjs_pkg::result_t              res;

    // Intermediate values of a tick.
    logic                          pull_now;
    logic                          srv_mid;
    logic [fjs_pkg::PAGE_BITS-1:0] pg_mid;
    logic [fjs_pkg::LEN_W-1:0]     cnt_mid;
    logic [fjs_pkg::SUM_W:0]       sum_wide;
    logic                          drop_now;
    logic                          write_now;

    // Divider.
    logic                          div_busy;
    logic [fjs_pkg::SUM_W-1:0]     div_quo;
    logic                          read_ok;
    logic [fjs_pkg::LEN_W-1:0]     avg_capped;

    function automatic logic [fjs_pkg::IDX_W-1:0] idx_inc(input logic [fjs_pkg::IDX_W-1:0] i);
        return (i == fjs_pkg::IDX_W'(fjs_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [fjs_pkg::TICK_W-1:0] sat_inc(input logic [fjs_pkg::TICK_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    fjs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (tick_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Submit decision.
    assign drop_now  = !(count_reg == '0 && !serving_reg)
                       && (count_reg >= fjs_pkg::LEN_W'(fjs_pkg::QUEUE_DEPTH));
    assign write_now = !(count_reg == '0 && !serving_reg) && !drop_now;

    // Next state of the queue, the server and the counters.
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        serving_next = serving_reg;
        pages_next   = pages_reg;
        work_next    = work_reg;
        idle_next    = idle_reg;
        tick_next    = tick_reg;
        sum_next     = sum_reg;
        peak_next    = peak_reg;
        pull_now     = !serving_reg && (count_reg != '0);
        srv_mid      = serving_reg | pull_now;
        pg_mid       = pull_now ? rd_data_reg : pages_reg;
        cnt_mid      = count_reg - fjs_pkg::LEN_W'(pull_now);
        sum_wide     = {1'b0, sum_reg} + (fjs_pkg::SUM_W + 1)'(cnt_mid);

        if (cmd.tick) begin
            // Pull if idle, serve one page, then account for the tick.
            if (pull_now) begin
                head_next = idx_inc(head_reg);
            end
            if (srv_mid) begin
                if (pg_mid <= fjs_pkg::PAGE_BITS'(1)) begin
                    serving_next = 1'b0;
                    pages_next   = '0;
                end else begin
                    serving_next = 1'b1;
                    pages_next   = pg_mid - 1'b1;
                end
                work_next = sat_inc(work_reg);
            end else begin
                idle_next = sat_inc(idle_reg);
            end
            tick_next  = sat_inc(tick_reg);
            sum_next   = sum_wide[fjs_pkg::SUM_W] ? '1 : sum_wide[fjs_pkg::SUM_W-1:0];
            count_next = cnt_mid;
            if (cnt_mid > peak_reg) begin
                peak_next = cnt_mid;
            end
        end

        if (cmd.pull && pull_now) begin
            // Second pull at the end of a tick.
            serving_next = 1'b1;
            pages_next   = rd_data_reg;
            head_next    = idx_inc(head_reg);
            count_next   = count_reg - 1'b1;
        end

        if (cmd.submit) begin
            if (count_reg == '0 && !serving_reg) begin
                serving_next = 1'b1;
                pages_next   = page_reg;
            end else if (write_now) begin
                tail_next  = idx_inc(tail_reg);
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Average capped at the queue depth, reported on a read only.
    assign read_ok    = (func_reg == fjs_pkg::FUNC_READ) && (tick_reg != '0);
    assign avg_capped = (div_quo > fjs_pkg::SUM_W'(fjs_pkg::QUEUE_DEPTH))
                        ? fjs_pkg::LEN_W'(fjs_pkg::QUEUE_DEPTH) : div_quo[fjs_pkg::LEN_W-1:0];

    // Result assembled from the state after the update.
    always_comb begin
        res                      = '0;
        res.job_dropped          = dropped_reg;
        res.busy_res             = serving_reg || (count_reg != '0);
        res.pages_left           = serving_reg ? pages_reg : '0;
        res.queue_length         = count_reg;
        res.work_ticks           = work_reg;
        res.idle_ticks           = idle_reg;
        res.elapsed_ticks        = tick_reg;
        res.max_queue_length     = peak_reg;
        res.average_queue_length = read_ok ? avg_capped : '0;
        res.average_valid        = read_ok;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            serving_reg   <= 1'b0;
            pages_reg     <= '0;
            work_reg      <= '0;
            idle_reg      <= '0;
            tick_reg      <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            serving_reg <= serving_next;
            pages_reg   <= pages_next;
            work_reg    <= work_next;
            idle_reg    <= idle_next;
            tick_reg    <= tick_next;
            sum_reg     <= sum_next;
            peak_reg    <= peak_next;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the job memory.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg    <= s_tuser;
            page_reg    <= s_tdata[fjs_pkg::PAGE_BITS-1:0];
            dropped_reg <= 1'b0;
        end else if (cmd.submit) begin
            dropped_reg <= drop_now;
        end
        if (cmd.submit && write_now) begin
            mem[tail_reg] <= page_reg;
        end
        rd_data_reg <= mem[head_reg];
        if (cmd.load) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.tick_zero = (tick_reg == '0);
    assign status.div_busy  = div_busy;
    assign status.out_free  = !out_valid_reg || m_tready;

    `FJS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= fjs_pkg::LEN_W'(fjs_pkg::QUEUE_DEPTH), "queue count above depth")
    `FJS_ASSERT_IMP(a_pages_serving, pages_reg != '0, serving_reg, "pages left without a job in service")
    `FJS_ASSERT_IMP(a_load_free, cmd.load && out_valid_reg, m_tready, "result overwritten before taken")

endmodule

@@ hw/rtl/fjs_ctrl.sv @@
// Request sequencer for the job server.
module fjs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic [fjs_pkg::FUNC_W-1:0]  s_tuser,
    output logic                        s_tready,
    input  fjs_pkg::dp_status_t         status,
    output fjs_pkg::dp_cmd_t            cmd
);

    `include "fifo_job_server_with_statistics_unit_macros.svh"

    fjs_pkg::state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fjs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (fjs_pkg::func_t'(s_tuser))
                        fjs_pkg::FUNC_TICK:   state_next = fjs_pkg::ST_TICK;
                        fjs_pkg::FUNC_SUBMIT: state_next = fjs_pkg::ST_SUBMIT;
                        fjs_pkg::FUNC_READ:   state_next = fjs_pkg::ST_DIV_START;
                        default:              state_next = fjs_pkg::ST_OUT;
                    endcase
                end
            end
            fjs_pkg::ST_TICK:   state_next = fjs_pkg::ST_WAIT;
            fjs_pkg::ST_WAIT:   state_next = fjs_pkg::ST_PULL;
            fjs_pkg::ST_PULL:   state_next = fjs_pkg::ST_OUT;
            fjs_pkg::ST_SUBMIT: state_next = fjs_pkg::ST_OUT;
            fjs_pkg::ST_DIV_START: begin
                state_next = status.tick_zero ? fjs_pkg::ST_OUT : fjs_pkg::ST_DIV;
            end
            fjs_pkg::ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = fjs_pkg::ST_OUT;
                end
            end
            fjs_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = fjs_pkg::ST_IDLE;
                end
            end
            default: state_next = fjs_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        s_tready      = (state_reg == fjs_pkg::ST_IDLE);
        cmd.accept    = s_tready && s_tvalid;
        cmd.tick      = (state_reg == fjs_pkg::ST_TICK);
        cmd.pull      = (state_reg == fjs_pkg::ST_PULL);
        cmd.submit    = (state_reg == fjs_pkg::ST_SUBMIT);
        cmd.div_start = (state_reg == fjs_pkg::ST_DIV_START) && !status.tick_zero;
        cmd.load      = (state_reg == fjs_pkg::ST_OUT) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fjs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `FJS_ASSERT_NEXT(a_accept_leaves_idle, cmd.accept, state_reg != fjs_pkg::ST_IDLE, "request accepted but controller stayed idle")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import fjs_pkg::*;

    // The request code that the block leaves unused.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int HOLD_AFTER = 150;
    localparam int LONG_HOLD  = 200;

    // Tracks the job server state and the status results that are still owed.
    class status_tracker;
        logic [PAGE_BITS-1:0] job_store [QUEUE_DEPTH];
        logic [IDX_W-1:0]     head;
        logic [IDX_W-1:0]     tail;
        logic [LEN_W-1:0]     queued;
        bit                   serving;
        logic [PAGE_BITS-1:0] pages_in_service;
        logic [TICK_W-1:0]    work_cnt;
        logic [TICK_W-1:0]    idle_cnt;
        logic [TICK_W-1:0]    tick_cnt;
        logic [SUM_W-1:0]     len_sum;
        logic [LEN_W-1:0]     len_peak;
        result_t              owed_status [$];
        int                   mismatch_count;
        int                   checked_count;
        int                   n_tick;
        int                   n_submit;
        int                   n_drop;
        int                   n_read;
        int                   n_unused;

        function new();
            head = '0;
            tail = '0;
            queued = '0;
            serving = 1'b0;
            pages_in_service = '0;
            work_cnt = '0;
            idle_cnt = '0;
            tick_cnt = '0;
            len_sum = '0;
            len_peak = '0;
        endfunction

        // An idle server takes the job at the head of the queue.
        function void pull_next();
            if (!serving && queued != 0) begin
                pages_in_service = job_store[head];
                serving = 1'b1;
                head = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
                queued = queued - 1'b1;
            end
        endfunction

        // Applies one accepted request and queues the status it must produce.
        function void note_request(logic [FUNC_W-1:0] func, logic [IN_DATA_W-1:0] data);
            result_t            want;
            logic [PAGE_BITS-1:0] pages;
            logic [SUM_W:0]     wide_sum;
            logic [SUM_W-1:0]   divisor;
            logic [SUM_W-1:0]   quotient;
            want = '0;
            pages = data[PAGE_BITS-1:0];
            if (func == FUNC_TICK) begin
                n_tick++;
                pull_next();
                if (serving) begin
                    if (pages_in_service <= 1) begin
                        pages_in_service = '0;
                        serving = 1'b0;
                    end else begin
                        pages_in_service = pages_in_service - 1'b1;
                    end
                    if (work_cnt != '1)
                        work_cnt = work_cnt + 1'b1;
                end else if (idle_cnt != '1) begin
                    idle_cnt = idle_cnt + 1'b1;
                end
                if (tick_cnt != '1)
                    tick_cnt = tick_cnt + 1'b1;
                wide_sum = {1'b0, len_sum} + (SUM_W + 1)'(queued);
                len_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
                if (queued > len_peak)
                    len_peak = queued;
                pull_next();
            end else if (func == FUNC_SUBMIT) begin
                n_submit++;
                if (queued == 0 && !serving) begin
                    serving = 1'b1;
                    pages_in_service = pages;
                end else if (queued >= QUEUE_DEPTH) begin
                    want.job_dropped = 1'b1;
                    n_drop++;
                end else begin
                    job_store[tail] = pages;
                    tail = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
                    queued = queued + 1'b1;
                end
            end else if (func == FUNC_READ) begin
                n_read++;
                // No average exists before the first tick.
                if (tick_cnt != 0) begin
                    divisor = SUM_W'(tick_cnt);
                    quotient = len_sum / divisor;
                    want.average_queue_length = (quotient > QUEUE_DEPTH) ?
                        LEN_W'(QUEUE_DEPTH) : quotient[LEN_W-1:0];
                    want.average_valid = 1'b1;
                end
            end else begin
                n_unused++;
            end
            want.busy_res = serving || queued != 0;
            want.pages_left = serving ? pages_in_service : '0;
            want.queue_length = queued;
            want.work_ticks = work_cnt;
            want.idle_ticks = idle_cnt;
            want.elapsed_ticks = tick_cnt;
            want.max_queue_length = len_peak;
            owed_status.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        // Compares one delivered status with the oldest one owed.
        function void check_status(result_t got);
            result_t want;
            if (owed_status.size() == 0) begin
                $display("%0t ns: status with no request pending, expected none, got %h",
                         $time, got);
                mismatch_count++;
                return;
            end
            want = owed_status.pop_front();
            checked_count++;
            compare_field("job_dropped", 64'(want.job_dropped), 64'(got.job_dropped));
            compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
            compare_field("pages_left", 64'(want.pages_left), 64'(got.pages_left));
            compare_field("queue_length", 64'(want.queue_length), 64'(got.queue_length));
            compare_field("work_ticks", 64'(want.work_ticks), 64'(got.work_ticks));
            compare_field("idle_ticks", 64'(want.idle_ticks), 64'(got.idle_ticks));
            compare_field("elapsed_ticks", 64'(want.elapsed_ticks), 64'(got.elapsed_ticks));
            compare_field("max_queue_length", 64'(want.max_queue_length),
                          64'(got.max_queue_length));
            compare_field("average_queue_length", 64'(want.average_queue_length),
                          64'(got.average_queue_length));
            compare_field("average_valid", 64'(want.average_valid), 64'(got.average_valid));
            compare_field("pad", 64'(want.pad), 64'(got.pad));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [15:0] page_count
    logic [FUNC_W-1:0]     s_tuser;   // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // result_t fields, job_dropped in bit 0

    status_tracker tracker;
    bit            quiet;
    bit            hold_done;
    int unsigned   sender_gap_pct;
    int            request_count;

    fifo_job_server_with_statistics_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Offers one request from a falling edge and returns at the falling edge after
    // it was accepted. The valid line stays high between back-to-back requests.
    task automatic issue_request(input logic [FUNC_W-1:0] func,
                                 input logic [IN_DATA_W-1:0] data);
        if (!quiet && $urandom_range(0, 99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_request(func, data);
        if (func != FUNC_UNUSED)
            request_count++;
        @(negedge aclk);
    endtask

    // Mostly short jobs so that the queue drains, now and then a longer one.
    function automatic logic [IN_DATA_W-1:0] pick_pages();
        if ($urandom_range(0, 9) == 0)
            return IN_DATA_W'($urandom_range(4, 24));
        return IN_DATA_W'($urandom_range(0, 3));
    endfunction

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_status(result_t'(m_tdata));
    end

    // Result receiver: random stalls, one long hold-off that backs up the block.
    initial begin : receiver
        int unsigned stall_pct;
        m_tready = 1'b0;
        stall_pct = 25;
        @(posedge aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 63) == 0)
                stall_pct = $urandom_range(0, 1) ? 25 : 0;
            if (!hold_done && !quiet && tracker.checked_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
        end
    end

    // Watchdog.
    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main stimulus.
    initial begin : stimulus
        int unsigned pick;
        int          drain;
        tracker = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_TICK;
        quiet = 1'b0;
        sender_gap_pct = 0;
        request_count = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: read before any tick, unused code, zero-page job,
        // direct service versus queueing, reads with time passed.
        issue_request(FUNC_READ, 16'h0000);
        issue_request(FUNC_UNUSED, 16'hFFFF);
        issue_request(FUNC_TICK, 16'h0000);
        issue_request(FUNC_SUBMIT, 16'h0000);
        issue_request(FUNC_TICK, 16'hFFFF);
        issue_request(FUNC_SUBMIT, 16'h0001);
        issue_request(FUNC_SUBMIT, 16'h0003);
        issue_request(FUNC_SUBMIT, 16'h0002);
        issue_request(FUNC_TICK, 16'h0000);
        issue_request(FUNC_TICK, 16'h0000);
        issue_request(FUNC_READ, 16'hFFFF);
        issue_request(FUNC_UNUSED, 16'h0000);
        repeat (4) issue_request(FUNC_TICK, 16'h0000);
        issue_request(FUNC_READ, 16'h0000);

        // Random part in episodes; the last stretch runs without any idling.
        while (request_count < 370) begin
            if (request_count >= 330)
                quiet = 1'b1;
            sender_gap_pct = (quiet || $urandom_range(0, 2) == 0) ? 0 : 30;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // A burst of job submits.
                repeat ($urandom_range(1, 8)) issue_request(FUNC_SUBMIT, pick_pages());
            end else if (pick < 38) begin
                // Fill the queue, then overflow it.
                while (tracker.queued < QUEUE_DEPTH)
                    issue_request(FUNC_SUBMIT, pick_pages());
                repeat ($urandom_range(1, 3))
                    issue_request(FUNC_SUBMIT, IN_DATA_W'($urandom));
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 30)) issue_request(FUNC_TICK, IN_DATA_W'($urandom));
            end else if (pick < 92) begin
                issue_request(FUNC_READ, IN_DATA_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 2))
                    issue_request(FUNC_UNUSED, IN_DATA_W'($urandom));
            end
        end

        // Drain the queue, then serve a job with every page bit set.
        drain = 0;
        while ((tracker.serving || tracker.queued != 0) && drain < 200) begin
            issue_request(FUNC_TICK, IN_DATA_W'($urandom));
            drain++;
        end
        issue_request(FUNC_SUBMIT, 16'hFFFF);
        issue_request(FUNC_TICK, 16'h0000);
        issue_request(FUNC_TICK, 16'h0000);
        issue_request(FUNC_READ, 16'h0000);
        s_tvalid <= 1'b0;

        // Wait for every owed status, then give a read time to surface.
        while (tracker.owed_status.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Covered %0d ticks, %0d submits (%0d dropped), %0d reads, %0d unused codes.",
                 tracker.n_tick, tracker.n_submit, tracker.n_drop, tracker.n_read,
                 tracker.n_unused);
        $display("Queue peaked at %0d jobs; %0d results checked across a %0d-cycle hold-off.",
                 tracker.len_peak, tracker.checked_count, LONG_HOLD);
        if (tracker.mismatch_count == 0 && tracker.owed_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/fjs_pkg.sv
hw/rtl/fjs_div.sv
hw/rtl/fjs_dp.sv
hw/rtl/fjs_ctrl.sv
hw/rtl/fifo_job_server_with_statistics_unit.sv
bench/tb.sv
